// ===== rtl/saw_pkg.sv =====
// Shared types, constants and codes for the stop-and-wait sender.
package saw_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [31:0] seq;
    logic [15:0] ref_h;
    logic [11:0] len;
  } desc_t;

  localparam int DESC_W = $bits(desc_t);

  typedef enum logic [1:0] {
    MODE_SEND    = 2'd0,
    MODE_ACK     = 2'd1,
    MODE_TIMEOUT = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FETCH,
    ST_LOAD
  } state_t;

  typedef enum logic [2:0] {
    OUT_NONE,
    OUT_IN,
    OUT_HEAD,
    OUT_RAM,
    OUT_DROP
  } out_sel_t;

  typedef struct packed {
    logic     capture;
    logic     push;
    logic     head_from_in;
    logic     pop;
    logic     rd_en;
    logic     head_from_ram;
    logic     set_await;
    logic     clr_await;
    logic     out_load;
    out_sel_t out_sel;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       full;
    logic       empty;
    logic       last_one;
    logic       ack_match;
    logic       awaiting;
    logic       out_free;
  } sts_t;

endpackage

// ===== rtl/saw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module saw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read, hold when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/saw_ctrl.sv =====
// Controller state machine of the stop-and-wait sender.
module saw_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  saw_pkg::sts_t sts,
  output saw_pkg::cmd_t cmd
);
  import saw_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.out_free) begin
          if (mode_t'(sts.mode) == MODE_ACK && !sts.empty && sts.ack_match &&
              !sts.last_one) begin
            state_nxt = ST_FETCH;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FETCH: state_nxt = ST_LOAD;
      ST_LOAD: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd         = '0;
    cmd.out_sel = OUT_NONE;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EXEC: begin
        if (sts.out_free) begin
          unique case (sts.mode)
            MODE_SEND: begin
              cmd.out_load = 1'b1;
              if (sts.full) begin
                cmd.out_sel = OUT_DROP;
              end else begin
                cmd.push = 1'b1;
                if (!sts.awaiting) begin
                  cmd.head_from_in = 1'b1;
                  cmd.set_await    = 1'b1;
                  cmd.out_sel      = OUT_IN;
                end
              end
            end
            MODE_ACK: begin
              if (!sts.empty && sts.ack_match) begin
                cmd.pop       = 1'b1;
                cmd.clr_await = 1'b1;
                // last frame retired: nothing more to send
                cmd.out_load  = sts.last_one;
              end else begin
                cmd.out_load = 1'b1;
              end
            end
            MODE_TIMEOUT: begin
              cmd.out_load = 1'b1;
              if (!sts.empty) cmd.out_sel = OUT_HEAD;
            end
            default: cmd.out_load = 1'b1;
          endcase
        end
      end
      ST_FETCH: cmd.rd_en = 1'b1;
      ST_LOAD: begin
        if (sts.out_free) begin
          cmd.head_from_ram = 1'b1;
          cmd.set_await     = 1'b1;
          cmd.out_load      = 1'b1;
          cmd.out_sel       = OUT_RAM;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/saw_dp.sv =====
// Datapath of the stop-and-wait sender: event capture, queue, head copy, result register.
module saw_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [1:0]               in_mode,
  input  logic [31:0]              in_frame_seq,
  input  logic [15:0]              in_frame_ref,
  input  logic [11:0]              in_frame_len,
  input  logic [31:0]              in_ack_number,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_transmit_valid,
  output logic [15:0]              out_transmit_ref,
  output logic [11:0]              out_transmit_len,
  output logic [31:0]              out_transmit_seq,
  output logic                     out_send_dropped,
  input  saw_pkg::cmd_t            cmd,
  output saw_pkg::sts_t            sts
);
  import saw_pkg::*;

  logic [1:0]       mode_r, mode_nxt;
  desc_t            in_desc_r, in_desc_nxt;
  logic [31:0]      ack_r, ack_nxt;
  desc_t            head_r, head_nxt;
  logic [IDX_W-1:0] head_idx_r, head_idx_nxt;
  logic [IDX_W-1:0] tail_idx_r, tail_idx_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             await_r, await_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             tx_valid_r, tx_valid_nxt;
  desc_t            tx_r, tx_nxt;
  logic             dropped_r, dropped_nxt;
  logic [DESC_W-1:0] rd_data;
  desc_t            ram_desc;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  // descriptor queue storage
  saw_ram #(
    .WIDTH (DESC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.push),
    .wr_addr (tail_idx_r),
    .wr_data (in_desc_r),
    .rd_en   (cmd.rd_en),
    .rd_addr (head_idx_r),
    .rd_data (rd_data)
  );

  assign ram_desc = desc_t'(rd_data);

  // capture the accepted event
  always_comb begin
    mode_nxt    = mode_r;
    in_desc_nxt = in_desc_r;
    ack_nxt     = ack_r;
    if (cmd.capture) begin
      mode_nxt          = in_mode;
      in_desc_nxt.seq   = in_frame_seq;
      in_desc_nxt.ref_h = in_frame_ref;
      in_desc_nxt.len   = in_frame_len;
      ack_nxt           = in_ack_number;
    end
  end

  // advance queue pointers, count and head copy
  always_comb begin
    head_idx_nxt = head_idx_r;
    tail_idx_nxt = tail_idx_r;
    count_nxt    = count_r;
    head_nxt     = head_r;
    await_nxt    = await_r;
    if (cmd.push) begin
      tail_idx_nxt = next_slot(tail_idx_r);
      count_nxt    = count_r + 1'b1;
    end
    if (cmd.pop) begin
      head_idx_nxt = next_slot(head_idx_r);
      count_nxt    = count_r - 1'b1;
    end
    if (cmd.head_from_in)  head_nxt = in_desc_r;
    if (cmd.head_from_ram) head_nxt = ram_desc;
    if (cmd.set_await)     await_nxt = 1'b1;
    if (cmd.clr_await)     await_nxt = 1'b0;
  end

  // load or drain the result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    tx_valid_nxt  = tx_valid_r;
    tx_nxt        = tx_r;
    dropped_nxt   = dropped_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      tx_valid_nxt  = 1'b0;
      tx_nxt        = '0;
      dropped_nxt   = 1'b0;
      case (cmd.out_sel)
        OUT_IN: begin
          tx_valid_nxt = 1'b1;
          tx_nxt       = in_desc_r;
        end
        OUT_HEAD: begin
          tx_valid_nxt = 1'b1;
          tx_nxt       = head_r;
        end
        OUT_RAM: begin
          tx_valid_nxt = 1'b1;
          tx_nxt       = ram_desc;
        end
        OUT_DROP: dropped_nxt = 1'b1;
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_idx_r  <= '0;
      tail_idx_r  <= '0;
      count_r     <= '0;
      await_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_idx_r  <= head_idx_nxt;
      tail_idx_r  <= tail_idx_nxt;
      count_r     <= count_nxt;
      await_r     <= await_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    in_desc_r  <= in_desc_nxt;
    ack_r      <= ack_nxt;
    head_r     <= head_nxt;
    tx_valid_r <= tx_valid_nxt;
    tx_r       <= tx_nxt;
    dropped_r  <= dropped_nxt;
  end

  // status to the controller
  always_comb begin
    sts.mode      = mode_r;
    sts.full      = (count_r == CNT_W'(QUEUE_DEPTH));
    sts.empty     = (count_r == '0);
    sts.last_one  = (count_r == CNT_W'(1));
    sts.ack_match = (head_r.seq == ack_r);
    sts.awaiting  = await_r;
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid          = out_valid_r;
  assign out_transmit_valid = tx_valid_r;
  assign out_transmit_ref   = tx_r.ref_h;
  assign out_transmit_len   = tx_r.len;
  assign out_transmit_seq   = tx_r.seq;
  assign out_send_dropped   = dropped_r;

endmodule

// ===== rtl/stop_and_wait_sender_top.sv =====
// Top level of the stop-and-wait ARQ sender: controller plus datapath.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    mode, frame_seq, frame_ref, frame_len, ack_number
//   out_     output     out_valid/out_ready  transmit_valid/ref/len/seq, send_dropped
//
// Each event gives one result. A send, a timeout or an unmatched acknowledgement
// passes through accept and execute; a matching acknowledgement with frames still
// queued adds fetch and load, since the next head descriptor is read from queue memory.
// Reset is synchronous, active low; it clears the indexes, count, outstanding flag
// and the result valid flag. The descriptor memory is not cleared.
// The next event is accepted while a result waits; execution stalls until the
// result register is free.
module stop_and_wait_sender_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_frame_seq,
  input  logic [15:0] in_frame_ref,
  input  logic [11:0] in_frame_len,
  input  logic [31:0] in_ack_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_transmit_valid,
  output logic [15:0] out_transmit_ref,
  output logic [11:0] out_transmit_len,
  output logic [31:0] out_transmit_seq,
  output logic        out_send_dropped
);
  import saw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing
  saw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // queue and result path
  saw_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_mode            (in_mode),
    .in_frame_seq       (in_frame_seq),
    .in_frame_ref       (in_frame_ref),
    .in_frame_len       (in_frame_len),
    .in_ack_number      (in_ack_number),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_transmit_valid (out_transmit_valid),
    .out_transmit_ref   (out_transmit_ref),
    .out_transmit_len   (out_transmit_len),
    .out_transmit_seq   (out_transmit_seq),
    .out_send_dropped   (out_send_dropped),
    .cmd                (cmd),
    .sts                (sts)
  );

  // one event in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second event accepted while one is in flight");

  // between events a frame is outstanding exactly when the queue is non-empty
  a_await_matches_queue: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (sts.awaiting == !sts.empty))
    else $error("outstanding flag disagrees with queue count");

  // a dropped send never transmits
  a_drop_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_send_dropped) |-> (!out_transmit_valid && out_transmit_seq == '0))
    else $error("dropped send carries a transmission");

  // the queue never pushes and pops together
  a_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.push && cmd.pop))
    else $error("queue push and pop in the same cycle");

endmodule

// ===== tb/sv/tb_stop_and_wait_sender_top.sv =====
// Testbench for the stop-and-wait ARQ sender: directed and random events, scoreboard check.
`timescale 1ns / 100ps

module tb_stop_and_wait_sender_top;
  import saw_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 400;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 20;

  typedef struct packed {
    logic        tx_valid;
    logic [15:0] handle;
    logic [11:0] len;
    logic [31:0] seq;
    logic        dropped;
  } tx_result_t;

  // Track the descriptor queue and the transmissions it must cause
  class arq_scoreboard;
    desc_t        slots[QUEUE_DEPTH];
    int unsigned  head;
    int unsigned  tail;
    int unsigned  count;
    bit           awaiting;
    tx_result_t   expected_tx[$];
    int unsigned  errors;

    function tx_result_t head_transmit();
      tx_result_t r;
      r          = '0;
      r.tx_valid = 1'b1;
      r.handle   = slots[head].ref_h;
      r.len      = slots[head].len;
      r.seq      = slots[head].seq;
      return r;
    endfunction

    // Apply one accepted transaction; return 1 unless the event was ignored
    function bit note_event(logic [1:0] mode, logic [31:0] seq, logic [15:0] handle,
                            logic [11:0] len, logic [31:0] ackn);
      tx_result_t r;
      bit         effective;
      r         = '0;
      effective = 1'b0;
      case (mode)
        MODE_SEND: begin
          effective = 1'b1;
          if (count == QUEUE_DEPTH) begin
            r.dropped = 1'b1;
          end else begin
            slots[tail].seq   = seq;
            slots[tail].ref_h = handle;
            slots[tail].len   = len;
            tail  = (tail + 1) % QUEUE_DEPTH;
            count = count + 1;
            if (!awaiting) begin
              awaiting = 1'b1;
              r = head_transmit();
            end
          end
        end
        MODE_ACK: begin
          if (count != 0 && slots[head].seq == ackn) begin
            effective = 1'b1;
            head     = (head + 1) % QUEUE_DEPTH;
            count    = count - 1;
            awaiting = 1'b0;
            if (count != 0) begin
              awaiting = 1'b1;
              r = head_transmit();
            end
          end
        end
        MODE_TIMEOUT: begin
          if (count != 0) begin
            effective = 1'b1;
            r = head_transmit();
          end
        end
        default: ;
      endcase
      expected_tx.insert(expected_tx.size(), r);
      return effective;
    endfunction

    // Compare one result transaction with the oldest expectation
    function void check_tx(tx_result_t got);
      tx_result_t exp;
      if (expected_tx.size() == 0) begin
        $error("result with none expected: valid %0d ref %h len %h seq %h dropped %0d",
               got.tx_valid, got.handle, got.len, got.seq, got.dropped);
        errors++;
        return;
      end
      exp = expected_tx[0];
      expected_tx.delete(0);
      if (got.tx_valid !== exp.tx_valid) begin
        $error("transmit_valid: expected %0d, actual %0d", exp.tx_valid, got.tx_valid);
        errors++;
      end
      if (got.handle !== exp.handle) begin
        $error("transmit_ref: expected %h, actual %h", exp.handle, got.handle);
        errors++;
      end
      if (got.len !== exp.len) begin
        $error("transmit_len: expected %h, actual %h", exp.len, got.len);
        errors++;
      end
      if (got.seq !== exp.seq) begin
        $error("transmit_seq: expected %h, actual %h", exp.seq, got.seq);
        errors++;
      end
      if (got.dropped !== exp.dropped) begin
        $error("send_dropped: expected %0d, actual %0d", exp.dropped, got.dropped);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = MODE_SEND;
  logic [31:0] in_frame_seq = '0;
  logic [15:0] in_frame_ref = '0;
  logic [11:0] in_frame_len = '0;
  logic [31:0] in_ack_number = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_transmit_valid;
  logic [15:0] out_transmit_ref;
  logic [11:0] out_transmit_len;
  logic [31:0] out_transmit_seq;
  logic        out_send_dropped;

  arq_scoreboard sb = new;
  int unsigned   send_idle_pct = 15;
  int unsigned   recv_idle_pct = 65;
  bit            hold_req = 1'b0;
  int unsigned   hold_left = 0;
  int unsigned   cycle_count = 0;

  stop_and_wait_sender_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_frame_seq       (in_frame_seq),
    .in_frame_ref       (in_frame_ref),
    .in_frame_len       (in_frame_len),
    .in_ack_number      (in_ack_number),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_transmit_valid (out_transmit_valid),
    .out_transmit_ref   (out_transmit_ref),
    .out_transmit_len   (out_transmit_len),
    .out_transmit_seq   (out_transmit_seq),
    .out_send_dropped   (out_send_dropped)
  );

  always #5 clk = ~clk;

  // Check result transactions, then pick the next out_ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_tx('{out_transmit_valid, out_transmit_ref, out_transmit_len,
                    out_transmit_seq, out_send_dropped});
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Abort a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Offer one event after a random gap and hold it until accepted
  task automatic drive_event(input logic [1:0] mode, input logic [31:0] seq,
                             input logic [15:0] handle, input logic [11:0] len,
                             input logic [31:0] ackn, output bit effective);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_frame_seq  <= seq;
    in_frame_ref  <= handle;
    in_frame_len  <= len;
    in_ack_number <= ackn;
    do @(posedge clk); while (!in_ready);
    effective = sb.note_event(mode, seq, handle, len, ackn);
  endtask

  initial begin
    bit          effective;
    int unsigned counted;
    int unsigned item_no;
    int unsigned send_pct;
    int unsigned pick;
    logic [1:0]  mode;
    logic [31:0] seq;
    logic [31:0] ackn;
    logic [31:0] word;
    logic [15:0] handle;
    logic [11:0] len;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-queue events, extremes, retransmit, mismatch, full queue
    drive_event(MODE_TIMEOUT, '0, '0, '0, '0, effective);
    drive_event(MODE_ACK, '0, '0, '0, '0, effective);
    drive_event(MODE_UNUSED, '0, '0, '0, '0, effective);
    drive_event(MODE_SEND, '0, '0, '0, '1, effective);
    drive_event(MODE_SEND, '1, '1, '1, '0, effective);
    drive_event(MODE_TIMEOUT, '1, '1, '1, '1, effective);
    drive_event(MODE_ACK, '0, '0, '0, '1, effective);
    for (int i = 0; i < QUEUE_DEPTH - 2; i++) begin
      drive_event(MODE_SEND, 32'(i) + 32'h100, 16'(i) + 16'h10, 12'(i) + 12'h20, '0,
                  effective);
    end
    drive_event(MODE_SEND, 32'hdead_beef, 16'h5a5a, 12'ha5a, '0, effective);
    drive_event(MODE_ACK, '1, '1, '1, '0, effective);
    drive_event(MODE_UNUSED, '1, '1, '1, '1, effective);

    // Random: alternate filling and draining stretches in each idling phase
    item_no  = 0;
    send_pct = 75;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 15; recv_idle_pct = 65; end
        1: begin send_idle_pct = 65; recv_idle_pct = 15; end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_req      = 1'b1;
        end
      endcase
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        word   = random_word();
        handle = word[15:0];
        word   = random_word();
        len    = word[11:0];
        seq    = random_word();
        ackn   = random_word();
        if ($urandom_range(0, 99) < send_pct) begin
          mode = MODE_SEND;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 65) begin
            mode = MODE_ACK;
            if (sb.count != 0) ackn = sb.slots[sb.head].seq;
          end else if (pick < 80) begin
            mode = MODE_ACK;
            if (sb.count != 0 && pick[0]) ackn = sb.slots[sb.head].seq + 1;
          end else if (pick < 95) begin
            mode = MODE_TIMEOUT;
          end else begin
            mode = MODE_UNUSED;
          end
        end
        drive_event(mode, seq, handle, len, ackn, effective);
        if (effective) counted++;
        item_no++;
        if (item_no % 60 == 0) send_pct = (send_pct == 75) ? 30 : 75;
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then allow for stragglers
    while (sb.expected_tx.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== stop_and_wait_sender_top.f =====
rtl/saw_pkg.sv
rtl/saw_ram.sv
rtl/saw_ctrl.sv
rtl/saw_dp.sv
rtl/stop_and_wait_sender_top.sv
tb/sv/tb_stop_and_wait_sender_top.sv
